// File: hw/rtl/bpc_pkg.sv
// Shared widths, scaling constants, register indexes and item types for the compensation block.
package bpc_pkg;

	// Field and register widths
	localparam int D_W    = 24;
	localparam int CAL_W  = 16;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 25;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TCO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TCO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TREF      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TSENS     = 3'd5;

	// Scaling: the temperature midpoint, and powers of two given as shifts
	localparam int TEMP_MID       = 2000;
	localparam int TREF_SHIFT     = 8;
	localparam int DT_SHIFT       = 23;
	localparam int OFF_SHIFT      = 16;
	localparam int SENS_SHIFT     = 15;
	localparam int OFF_TCO_SHIFT  = 7;
	localparam int SENS_TCO_SHIFT = 8;
	localparam int T2_SHIFT       = 31;
	localparam int P_SENS_SHIFT   = 21;
	localparam int P_SHIFT        = 15;

	// Internal widths
	localparam int DT_W   = D_W + 1;
	localparam int PROD_W = DT_W + CAL_W + 1;
	localparam int Q_W    = PROD_W - DT_SHIFT;
	localparam int T2_W   = 2 * D_W - T2_SHIFT;
	localparam int OFF_W  = 40;
	localparam int SENS_W = 40;

	// Pipeline depths and default queue depth
	localparam int FRONT_STAGES = 3;
	localparam int BACK_STAGES  = 6;
	localparam int BPC_QDEPTH   = 4;

	typedef struct packed {
		logic [CAL_W-1:0] sens_base;
		logic [CAL_W-1:0] off_base;
		logic [CAL_W-1:0] sens_tco;
		logic [CAL_W-1:0] off_tco;
		logic [CAL_W-1:0] tref;
		logic [CAL_W-1:0] tsens;
	} cal_t;

	// First-order results handed from the front end to the back end
	typedef struct packed {
		logic [D_W-1:0]           d1;
		logic signed [Q_W-1:0]    q;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
		logic [T2_W-1:0]          t2;
		logic                     cold;
	} fq_t;

endpackage

// File: hw/rtl/bpc_in_if.sv
// Sample channel: raw pressure and temperature conversions with valid/ready.
interface bpc_in_if import bpc_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [D_W-1:0] raw_pressure;
	logic [D_W-1:0] raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// File: hw/rtl/bpc_out_if.sv
// Result channel: compensated temperature and pressure with valid/ready.
interface bpc_out_if import bpc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic signed [PRES_W-1:0] pressure_centi;

	modport source (output valid, output temperature_centi, output pressure_centi, input ready);
	modport sink   (input valid, input temperature_centi, input pressure_centi, output ready);
endinterface

// File: hw/rtl/bpc_front.sv
// Front end: accepts sample items, forms dT, first-order offset and sensitivity, flags cold items.
module bpc_front import bpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cal_t      cal,
	bpc_in_if.sink    sample,
	output logic      push,
	output fq_t       push_data,
	input  logic      full
);

	localparam logic signed [PROD_W-1:0] DT_BIAS   = PROD_W'((1 << DT_SHIFT) - 1);
	localparam logic signed [PROD_W-1:0] OFF_BIAS  = PROD_W'((1 << OFF_TCO_SHIFT) - 1);
	localparam logic signed [PROD_W-1:0] SENS_BIAS = PROD_W'((1 << SENS_TCO_SHIFT) - 1);
	localparam logic signed [PROD_W-1:0] NO_BIAS   = PROD_W'(0);

	logic [FRONT_STAGES:1]   vld_q;
	logic [FRONT_STAGES+1:1] adv;
	logic [FRONT_STAGES-1:0] src_v;

	// stage 1
	logic [D_W-1:0]         d1_s1;
	logic signed [DT_W-1:0] dt_s1;
	// stage 2
	logic [D_W-1:0]           d1_s2;
	logic signed [PROD_W-1:0] pt_s2;
	logic signed [PROD_W-1:0] po_s2;
	logic signed [PROD_W-1:0] ps_s2;
	logic [2*D_W-1:0]         dd_s2;
	// stage 3
	fq_t entry_s3;

	logic signed [DT_W-1:0]                  dt_c;
	logic signed [PROD_W-1:0]                pt_c;
	logic signed [PROD_W-1:0]                po_c;
	logic signed [PROD_W-1:0]                ps_c;
	logic signed [2*DT_W-1:0]                dd_c;
	logic signed [PROD_W-1:0]                pt_adj;
	logic signed [PROD_W-1:0]                po_adj;
	logic signed [PROD_W-1:0]                ps_adj;
	logic signed [PROD_W-OFF_TCO_SHIFT-1:0]  off_t;
	logic signed [PROD_W-SENS_TCO_SHIFT-1:0] sens_t;
	logic signed [OFF_W-1:0]                 off_base_c;
	logic signed [SENS_W-1:0]                sens_base_c;
	fq_t                                     entry_c;

	// stall chain: a stage moves on when empty or when the next one moves
	always_comb begin
		adv[FRONT_STAGES+1] = !full;
		for (int i = FRONT_STAGES; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
		src_v = {vld_q[FRONT_STAGES-1:1], sample.valid};
	end

	assign sample.ready = adv[1];
	assign push         = vld_q[FRONT_STAGES] && !full;
	assign push_data    = entry_s3;

	always_comb begin
		dt_c = $signed({1'b0, sample.raw_temperature})
			- $signed({1'b0, cal.tref, {TREF_SHIFT{1'b0}}});

		pt_c = dt_s1 * $signed({1'b0, cal.tsens});
		po_c = dt_s1 * $signed({1'b0, cal.off_tco});
		ps_c = dt_s1 * $signed({1'b0, cal.sens_tco});
		dd_c = dt_s1 * dt_s1;

		// bias negative values before the shift so the quotient truncates toward zero
		pt_adj = pt_s2 + (pt_s2[PROD_W-1] ? DT_BIAS : NO_BIAS);
		po_adj = po_s2 + (po_s2[PROD_W-1] ? OFF_BIAS : NO_BIAS);
		ps_adj = ps_s2 + (ps_s2[PROD_W-1] ? SENS_BIAS : NO_BIAS);
		off_t  = po_adj[PROD_W-1:OFF_TCO_SHIFT];
		sens_t = ps_adj[PROD_W-1:SENS_TCO_SHIFT];

		off_base_c  = $signed({{(OFF_W-CAL_W-OFF_SHIFT){1'b0}}, cal.off_base,
			{OFF_SHIFT{1'b0}}});
		sens_base_c = $signed({{(SENS_W-CAL_W-SENS_SHIFT){1'b0}}, cal.sens_base,
			{SENS_SHIFT{1'b0}}});

		entry_c.d1   = d1_s2;
		entry_c.q    = pt_adj[PROD_W-1:DT_SHIFT];
		entry_c.off  = off_base_c + off_t;
		entry_c.sens = sens_base_c + sens_t;
		entry_c.t2   = dd_s2[2*D_W-1:T2_SHIFT];
		entry_c.cold = pt_adj[PROD_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= FRONT_STAGES; i++) begin
				if (adv[i]) begin
					vld_q[i] <= src_v[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d1_s1 <= sample.raw_pressure;
			dt_s1 <= dt_c;
		end
		if (adv[2]) begin
			d1_s2 <= d1_s1;
			pt_s2 <= pt_c;
			po_s2 <= po_c;
			ps_s2 <= ps_c;
			dd_s2 <= dd_c[2*D_W-1:0];
		end
		if (adv[3]) begin
			entry_s3 <= entry_c;
		end
	end

endmodule

// File: hw/rtl/bpc_fifo.sv
// Short queue of first-order items between the front and back ends.
module bpc_fifo import bpc_pkg::*; #(
	parameter int unsigned Depth = BPC_QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fq_t  wdata,
	output logic full,
	input  logic pop,
	output fq_t  rdata,
	output logic empty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	fq_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CntW'(Depth));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: hw/rtl/bpc_back.sv
// Back end: second-order correction below 20 degC, then pressure from sensitivity and offset.
module bpc_back import bpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fq_t        head,
	input  logic       empty,
	output logic       pop,
	bpc_out_if.source  result
);

	localparam int QQ_W  = 2 * Q_W - 3;
	localparam int SPLIT = 20;
	localparam int PL_W  = D_W + SPLIT;
	localparam int PH_W  = D_W + SENS_W - SPLIT + 1;
	localparam int X_W   = D_W + SENS_W;
	localparam int P1_W  = X_W - P_SENS_SHIFT;
	localparam int Y_W   = P1_W + 1;
	localparam logic signed [X_W-1:0] X_BIAS  = X_W'((64'd1 << P_SENS_SHIFT) - 64'd1);
	localparam logic signed [X_W-1:0] X_ZERO  = X_W'(0);
	localparam logic signed [Y_W-1:0] Y_BIAS  = Y_W'((1 << P_SHIFT) - 1);
	localparam logic signed [Y_W-1:0] Y_ZERO  = Y_W'(0);

	logic [BACK_STAGES:1]   vld_q;
	logic [BACK_STAGES+1:1] adv;
	logic [BACK_STAGES-1:0] src_v;

	// stage 1
	logic [D_W-1:0]           d1_s1;
	logic [QQ_W-1:0]          qq_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic signed [OFF_W-1:0]  off_s1;
	logic signed [SENS_W-1:0] sens_s1;
	logic                     cold_s1;
	// stage 2
	logic [D_W-1:0]           d1_s2;
	logic signed [TEMP_W-1:0] temp_s2;
	logic signed [OFF_W-1:0]  off_s2;
	logic signed [SENS_W-1:0] sens_s2;
	// stage 3
	logic [PL_W-1:0]          pl_s3;
	logic signed [PH_W-1:0]   ph_s3;
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [OFF_W-1:0]  off_s3;
	// stage 4
	logic signed [X_W-1:0]    x_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic signed [OFF_W-1:0]  off_s4;
	// stage 5
	logic signed [Y_W-1:0]    y_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	// stage 6
	logic signed [TEMP_W-1:0] temp_s6;
	logic signed [PRES_W-1:0] pres_s6;

	logic signed [Q_W-1:0]      q_c;
	logic signed [2*Q_W-1:0]    qq_c;
	logic signed [TEMP_W:0]     tmid_c;
	logic signed [TEMP_W:0]     t2_c;
	logic signed [TEMP_W:0]     temp_c;
	logic [QQ_W+1:0]            sq5_c;
	logic signed [OFF_W-1:0]    off_corr_c;
	logic signed [SENS_W-1:0]   sens_corr_c;
	logic signed [SENS_W-1:0]   sens_c;
	logic signed [OFF_W-1:0]    off_c;
	logic [SPLIT-1:0]           sl_c;
	logic signed [SENS_W-SPLIT-1:0] sh_c;
	logic [PL_W-1:0]            pl_c;
	logic signed [PH_W-1:0]     ph_c;
	logic signed [X_W-1:0]      x_c;
	logic signed [X_W-1:0]      x_adj;
	logic signed [P1_W-1:0]     p1_c;
	logic signed [Y_W-1:0]      y_c;
	logic signed [Y_W-1:0]      y_adj;
	logic signed [Y_W-P_SHIFT-1:0] p_c;

	always_comb begin
		adv[BACK_STAGES+1] = result.ready;
		for (int i = BACK_STAGES; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
		src_v = {vld_q[BACK_STAGES-1:1], !empty};
	end

	assign pop                      = !empty && adv[1];
	assign result.valid             = vld_q[BACK_STAGES];
	assign result.temperature_centi = temp_s6;
	assign result.pressure_centi    = pres_s6;

	always_comb begin
		// stage 1: square of (T - 20 degC) and the corrected temperature
		q_c    = head.q;
		qq_c   = q_c * q_c;
		tmid_c = (TEMP_W+1)'(TEMP_MID);
		t2_c   = head.cold ? $signed({{(TEMP_W+1-T2_W){1'b0}}, head.t2}) : '0;
		temp_c = tmid_c + q_c - t2_c;

		// stage 2: five times the square, halved for offset, quartered for sensitivity
		sq5_c       = {qq_s1, 2'b00} + {2'b00, qq_s1};
		off_corr_c  = cold_s1 ? $signed({{(OFF_W-QQ_W-1){1'b0}}, sq5_c[QQ_W+1:1]}) : '0;
		sens_corr_c = cold_s1 ? $signed({{(SENS_W-QQ_W){1'b0}}, sq5_c[QQ_W+1:2]}) : '0;
		off_c       = off_s1 - off_corr_c;
		sens_c      = sens_s1 - sens_corr_c;

		// stage 3: D1 * SENS as two partial products
		sl_c = sens_s2[SPLIT-1:0];
		sh_c = sens_s2[SENS_W-1:SPLIT];
		pl_c = d1_s2 * sl_c;
		ph_c = $signed({1'b0, d1_s2}) * sh_c;

		// stage 4: recombine
		x_c = $signed({ph_s3[X_W-SPLIT-1:0], {SPLIT{1'b0}}})
			+ $signed({{(X_W-PL_W){1'b0}}, pl_s3});

		// stage 5: truncating divide, subtract offset
		x_adj = x_s4 + (x_s4[X_W-1] ? X_BIAS : X_ZERO);
		p1_c  = x_adj[X_W-1:P_SENS_SHIFT];
		y_c   = p1_c - off_s4;

		// stage 6: truncating divide
		y_adj = y_s5 + (y_s5[Y_W-1] ? Y_BIAS : Y_ZERO);
		p_c   = y_adj[Y_W-1:P_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= BACK_STAGES; i++) begin
				if (adv[i]) begin
					vld_q[i] <= src_v[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d1_s1   <= head.d1;
			qq_s1   <= qq_c[QQ_W-1:0];
			temp_s1 <= temp_c[TEMP_W-1:0];
			off_s1  <= head.off;
			sens_s1 <= head.sens;
			cold_s1 <= head.cold;
		end
		if (adv[2]) begin
			d1_s2   <= d1_s1;
			temp_s2 <= temp_s1;
			off_s2  <= off_c;
			sens_s2 <= sens_c;
		end
		if (adv[3]) begin
			pl_s3   <= pl_c;
			ph_s3   <= ph_c;
			temp_s3 <= temp_s2;
			off_s3  <= off_s2;
		end
		if (adv[4]) begin
			x_s4    <= x_c;
			temp_s4 <= temp_s3;
			off_s4  <= off_s3;
		end
		if (adv[5]) begin
			y_s5    <= y_c;
			temp_s5 <= temp_s4;
		end
		if (adv[6]) begin
			temp_s6 <= temp_s5;
			pres_s6 <= p_c[PRES_W-1:0];
		end
	end

endmodule

// File: hw/rtl/baro_pressure_temp_compensate_core.sv
// Throughput: one item per cycle while result ready stays high, set by the 3-stage front end
// and 6-stage back end pipelines.
// A queue of QDepth items sits between the two halves; a stalled result backs up the back end,
// then the queue, then the front end, before sample ready drops.
// Reset: asynchronous, active low; clears pipeline valid bits, queue pointers and all six
// calibration words to zero. No clearing pass; items are accepted straight after reset.
module baro_pressure_temp_compensate_core import bpc_pkg::*; #(
	parameter int unsigned QDepth = BPC_QDEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CAL_W-1:0]     cfg_data,
	bpc_in_if.sink               sample,
	bpc_out_if.source            result
);

	cal_t cal_q;
	logic push;
	fq_t  push_data;
	logic full;
	logic pop;
	fq_t  head;
	logic empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SENS_BASE: cal_q.sens_base <= cfg_data;
				REG_OFF_BASE:  cal_q.off_base  <= cfg_data;
				REG_SENS_TCO:  cal_q.sens_tco  <= cfg_data;
				REG_OFF_TCO:   cal_q.off_tco   <= cfg_data;
				REG_TREF:      cal_q.tref      <= cfg_data;
				REG_TSENS:     cal_q.tsens     <= cfg_data;
				default: ;
			endcase
		end
	end

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.sample    (sample),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	bpc_fifo #(
		.Depth (QDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	bpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// File: hw/rtl/bpc_checker.sv
// Port-level checks on the compensation core, bound to the top level.
module bpc_checker import bpc_pkg::*; #(
	parameter int unsigned QDepth = BPC_QDEPTH
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [TEMP_W-1:0] temperature_centi,
	input logic signed [PRES_W-1:0] pressure_centi
);

	localparam int Cap  = FRONT_STAGES + QDepth + BACK_STAGES;
	localparam int CntW = $clog2(Cap + 2);

	logic [CntW-1:0] inflight_q;
	logic            in_acc;
	logic            out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature_centi) && $stable(pressure_centi))
		else $error("result payload changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result offered with no item in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CntW'(Cap))
		else $error("more items in flight than the pipeline holds");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> in_ready)
		else $error("sample not ready while empty");

endmodule

bind baro_pressure_temp_compensate_core bpc_checker #(
	.QDepth (QDepth)
) u_bpc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (sample.valid),
	.in_ready          (sample.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.temperature_centi (result.temperature_centi),
	.pressure_centi    (result.pressure_centi)
);
